### hw/rtl/fir_filter_with_bypass_macros.svh
// ----------------------------------------------------------------------------
// fir_filter_with_bypass assertion macros
// Concurrent assertion wrappers; they expand to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef FIR_FILTER_WITH_BYPASS_MACROS_SVH
`define FIR_FILTER_WITH_BYPASS_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication.
`define FFB_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define FFB_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FFB_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define FFB_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

### hw/rtl/ffb_pkg.sv
// ----------------------------------------------------------------------------
// ffb_pkg
// Shared constants and types of the FIR filter with bypass.
// ----------------------------------------------------------------------------
`default_nettype none

package ffb_pkg;

  // Coefficient format is fixed at Q1.15.
  localparam int COEF_BITS = 16;
  localparam int FRAC_BITS = 15;

  localparam int MODE_W = 2;
  localparam logic [MODE_W-1:0] MODE_FILTER = 2'd0;
  localparam logic [MODE_W-1:0] MODE_COEF   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

  // Control of the multiply-accumulate datapath.
  typedef struct packed {
    logic clr;      // clear the accumulator
    logic mul_en;   // memory read data valid, register the product
    logic hist_ok;  // history word was written since the last clear
    logic acc_en;   // add the registered product
    logic fin_en;   // round and saturate the accumulator
  } mac_ctl_t;

endpackage

`default_nettype wire

### hw/rtl/fir_filter_with_bypass.sv
// ----------------------------------------------------------------------------
// fir_filter_with_bypass
// Runtime-loadable direct-form FIR filter for audio with a bypass mode.
//
// Usage: one input channel (in_valid/in_stall) carries a mode and its payload.
// Mode 0 filters in_sample_in and returns one transaction on the output
// channel (out_valid/out_stall); mode 1 writes coefficient in_coef_index;
// mode 2 clears the sample history; mode 3 is ignored. Modes 1 to 3 give no
// output. cfg_we/cfg_wdata load tap_count, to be written only while the block
// idles; the block itself does not enforce this. A filtered sample, with
// tap_count capped at MAX_TAPS, passes through S_RUN, which makes one
// coefficient and one history read per tap from the two RAMs; S_DRAIN, which
// waits for the read and product stages to empty; S_FIN, which rounds and
// saturates; and S_DONE, which loads the output register, after which the
// block returns to S_IDLE for the next item. With tap_count zero the sample
// skips to S_DONE, unchanged; writes, clears and mode 3 stay idle. in_stall is
// high while a sample is being worked on, so items are taken one at a time;
// the output register holds a finished sample while the next item is accepted.
// When the receiver stalls, a newly finished result waits and in_stall stays
// high. Reset clears the control state, the ring position and the history fill
// count, so the history reads as zeros with no clearing pass. Coefficients are
// undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none
`include "fir_filter_with_bypass_macros.svh"

module fir_filter_with_bypass import ffb_pkg::*; #(
  parameter int MAX_TAPS    = 512,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                                          clk,
  input  wire logic                                          rst_n,
  input  wire logic                                          cfg_we,
  input  wire logic [$clog2(MAX_TAPS + 1)-1:0]               cfg_wdata,
  input  wire logic                                          in_valid,
  output logic                                               in_stall,
  input  wire logic [MODE_W-1:0]                             in_mode,
  input  wire logic signed [SAMPLE_BITS-1:0]                 in_sample_in,
  input  wire logic [((MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1)-1:0] in_coef_index,
  input  wire logic signed [COEF_BITS-1:0]                   in_coef_value,
  output logic                                               out_valid,
  input  wire logic                                          out_stall,
  output logic signed [SAMPLE_BITS-1:0]                      out_sample_out,
  output logic                                               out_bypassed
);

  localparam int AW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int TAP_W = $clog2(MAX_TAPS + 1);
  localparam int ACC_W = COEF_BITS + SAMPLE_BITS + $clog2(MAX_TAPS) + 1;
  localparam logic [AW-1:0]    LAST_SLOT = AW'(MAX_TAPS - 1);
  localparam logic [TAP_W-1:0] TAPS_MAX  = TAP_W'(MAX_TAPS);
  localparam logic [AW:0]      IDX_LIMIT = (AW + 1)'(MAX_TAPS);

  localparam int ST_W = 3;
  localparam logic [ST_W-1:0] S_IDLE  = 3'd0;
  localparam logic [ST_W-1:0] S_RUN   = 3'd1;
  localparam logic [ST_W-1:0] S_DRAIN = 3'd2;
  localparam logic [ST_W-1:0] S_FIN   = 3'd3;
  localparam logic [ST_W-1:0] S_DONE  = 3'd4;

  logic [ST_W-1:0]  state_r, state_nxt;
  logic [TAP_W-1:0] tap_count_r;
  logic [TAP_W-1:0] taps_eff;
  logic [TAP_W-1:0] taps_r, taps_nxt;
  logic [TAP_W-1:0] kcnt_r, kcnt_nxt;
  logic [TAP_W-1:0] fill_r, fill_nxt;
  logic [AW-1:0]    pos_r, pos_nxt;
  logic [AW-1:0]    slot_r, slot_nxt;
  logic             v1_r, v2_r, ok1_r;
  logic             slot_ok;
  logic             last_tap;
  logic             accept;
  logic             out_free;
  logic             coef_we, hist_we;
  logic             byp_r, byp_nxt;
  logic signed [SAMPLE_BITS-1:0] x_r, x_nxt;
  logic signed [COEF_BITS-1:0]   coef_q;
  logic signed [SAMPLE_BITS-1:0] hist_q;
  logic signed [SAMPLE_BITS-1:0] mac_res;
  logic                          out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] out_sample_r, out_sample_nxt;
  logic                          out_byp_r, out_byp_nxt;
  mac_ctl_t                      mac_ctl;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign taps_eff = (tap_count_r > TAPS_MAX) ? TAPS_MAX : tap_count_r;
  assign last_tap = (kcnt_r == taps_r - TAP_W'(1));
  assign out_free = !out_valid_r || !out_stall;

  // The ring is filled in order from slot zero after a clear, so a slot holds
  // a written sample exactly when it lies below the fill count.
  assign slot_ok = (TAP_W'(slot_r) < fill_r);

  assign coef_we = accept && (in_mode == MODE_COEF) && ({1'b0, in_coef_index} < IDX_LIMIT);
  // The new sample is written at acceptance and read back no earlier than the
  // next cycle, so the read of the newest slot never overlaps its write.
  assign hist_we = accept && (in_mode == MODE_FILTER) && (taps_eff != '0);

  ffb_ram #(
    .WIDTH (COEF_BITS),
    .DEPTH (MAX_TAPS)
  ) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (in_coef_index),
    .wdata (in_coef_value),
    .raddr (kcnt_r[AW-1:0]),
    .rdata (coef_q)
  );

  ffb_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_TAPS)
  ) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (pos_r),
    .wdata (in_sample_in),
    .raddr (slot_r),
    .rdata (hist_q)
  );

  always_comb begin
    mac_ctl.clr     = hist_we;
    mac_ctl.mul_en  = v1_r;
    mac_ctl.hist_ok = ok1_r;
    mac_ctl.acc_en  = v2_r;
    mac_ctl.fin_en  = (state_r == S_FIN);
  end

  ffb_mac #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .ACC_W       (ACC_W)
  ) u_mac (
    .clk  (clk),
    .ctl  (mac_ctl),
    .coef (coef_q),
    .hist (hist_q),
    .res  (mac_res)
  );

  always_comb begin
    state_nxt = state_r;
    taps_nxt  = taps_r;
    kcnt_nxt  = kcnt_r;
    fill_nxt  = fill_r;
    pos_nxt   = pos_r;
    slot_nxt  = slot_r;
    x_nxt     = x_r;
    byp_nxt   = byp_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_mode)
            MODE_FILTER: begin
              x_nxt = in_sample_in;
              if (taps_eff == '0) begin
                byp_nxt   = 1'b1;
                state_nxt = S_DONE;
              end else begin
                byp_nxt   = 1'b0;
                taps_nxt  = taps_eff;
                kcnt_nxt  = '0;
                slot_nxt  = pos_r;
                pos_nxt   = (pos_r == LAST_SLOT) ? '0 : pos_r + AW'(1);
                fill_nxt  = (fill_r == TAPS_MAX) ? TAPS_MAX : fill_r + TAP_W'(1);
                state_nxt = S_RUN;
              end
            end
            MODE_CLEAR: begin
              pos_nxt  = '0;
              fill_nxt = '0;
            end
            default: begin
              // Coefficient writes go straight to the RAM; mode 3 does nothing.
            end
          endcase
        end
      end
      S_RUN: begin
        kcnt_nxt = kcnt_r + TAP_W'(1);
        slot_nxt = (slot_r == '0) ? LAST_SLOT : slot_r - AW'(1);
        if (last_tap) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!v1_r && !v2_r) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt  = out_valid_r && out_stall;
    out_sample_nxt = out_sample_r;
    out_byp_nxt    = out_byp_r;
    if ((state_r == S_DONE) && out_free) begin
      out_valid_nxt  = 1'b1;
      out_sample_nxt = byp_r ? x_r : mac_res;
      out_byp_nxt    = byp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tap_count_r <= '0;
      fill_r      <= '0;
      pos_r       <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        tap_count_r <= cfg_wdata;
      end
      fill_r      <= fill_nxt;
      pos_r       <= pos_nxt;
      v1_r        <= (state_r == S_RUN);
      v2_r        <= v1_r;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    taps_r       <= taps_nxt;
    kcnt_r       <= kcnt_nxt;
    slot_r       <= slot_nxt;
    ok1_r        <= slot_ok;
    x_r          <= x_nxt;
    byp_r        <= byp_nxt;
    out_sample_r <= out_sample_nxt;
    out_byp_r    <= out_byp_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_bypassed   = out_byp_r;

  `FFB_ASSERT_IMP(a_idle_pipe_empty, clk, rst_n, state_r == S_IDLE, !v1_r && !v2_r, "MAC pipeline busy while idle")
  `FFB_ASSERT_IMP(a_fill_tracks_pos, clk, rst_n, fill_r < TAPS_MAX, TAP_W'(pos_r) == fill_r, "ring position and fill count disagree")
  `FFB_ASSERT_NXT(a_done_loads_out, clk, rst_n, state_r == S_DONE && out_free, out_valid_r && state_r == S_IDLE, "finished result not loaded")
  `FFB_ASSERT_NXT(a_filter_starts, clk, rst_n, hist_we, state_r == S_RUN && kcnt_r == '0, "filter run did not start")

endmodule

`default_nettype wire

### hw/rtl/ffb_ram.sv
// ----------------------------------------------------------------------------
// ffb_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ffb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### hw/rtl/ffb_mac.sv
// ----------------------------------------------------------------------------
// ffb_mac
// Multiply-accumulate datapath with round-to-nearest and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module ffb_mac import ffb_pkg::*; #(
  parameter int SAMPLE_BITS = 16,
  parameter int ACC_W       = 42
) (
  input  wire logic                          clk,
  input  wire mac_ctl_t                      ctl,
  input  wire logic signed [COEF_BITS-1:0]   coef,
  input  wire logic signed [SAMPLE_BITS-1:0] hist,
  output logic signed [SAMPLE_BITS-1:0]      res
);

  localparam int PW = COEF_BITS + SAMPLE_BITS;
  localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(2 ** (FRAC_BITS - 1));
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(2 ** (SAMPLE_BITS - 1) - 1);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-(2 ** (SAMPLE_BITS - 1)));

  logic signed [SAMPLE_BITS-1:0] hist_m;
  logic signed [PW-1:0]          prod_nxt;
  logic signed [PW-1:0]          prod_r;
  logic signed [ACC_W-1:0]       acc_nxt;
  logic signed [ACC_W-1:0]       acc_r;
  logic signed [ACC_W-1:0]       rnd_sum;
  logic signed [ACC_W-1:0]       shifted;
  logic signed [SAMPLE_BITS-1:0] res_nxt;
  logic signed [SAMPLE_BITS-1:0] res_r;

  // History words not written since the last clear read as zero.
  assign hist_m   = ctl.hist_ok ? hist : '0;
  assign prod_nxt = coef * hist_m;

  always_comb begin
    acc_nxt = acc_r;
    if (ctl.clr) begin
      acc_nxt = '0;
    end else if (ctl.acc_en) begin
      acc_nxt = acc_r + {{(ACC_W - PW){prod_r[PW-1]}}, prod_r};
    end
  end

  assign rnd_sum = acc_r + ROUND_BIAS;
  assign shifted = rnd_sum >>> FRAC_BITS;

  always_comb begin
    if (shifted > SAT_HI) begin
      res_nxt = SAT_HI[SAMPLE_BITS-1:0];
    end else if (shifted < SAT_LO) begin
      res_nxt = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      res_nxt = shifted[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= prod_nxt;
    end
    acc_r <= acc_nxt;
    if (ctl.fin_en) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

`default_nettype wire
